/* rtl/b64d_pkg.sv */
// ----------------------------------------------------------------------------
// b64d_pkg: shared types and the alphabet decode for the base64 stream decoder
// Holds the character class codes, the queue entry type and the sextet lookup.
// ----------------------------------------------------------------------------
package b64d_pkg;

    localparam int unsigned QueueDepth = 2;
    localparam int unsigned QueuePtrW  = 1;
    localparam int unsigned QueueCntW  = 2;

    // Class of one input character
    typedef enum logic [1:0] {
        CLS_SKIP = 2'd0,   // '=', newline, carriage return
        CLS_BAD  = 2'd1,   // outside the alphabet
        CLS_DATA = 2'd2    // alphabet character, carries a sextet
    } t_cls;

    // One classified character on its way from front to back
    typedef struct packed {
        t_cls       cls;
        logic [5:0] sextet;
        logic       last;
    } t_entry;

    // Queue occupancy seen by both sides
    typedef struct packed {
        logic empty;
        logic full;
    } t_q_status;

    // Classify a character and give its six-bit value
    function automatic t_entry classify(input logic [7:0] c, input logic last);
        t_entry e;
        e.last   = last;
        e.sextet = 6'd0;
        e.cls    = CLS_BAD;
        case (c) inside
            [8'h41:8'h5A]: begin
                e.cls    = CLS_DATA;
                e.sextet = 6'(c - 8'h41);
            end
            [8'h61:8'h7A]: begin
                e.cls    = CLS_DATA;
                e.sextet = 6'(c - 8'h61 + 8'd26);
            end
            [8'h30:8'h39]: begin
                e.cls    = CLS_DATA;
                e.sextet = 6'(c - 8'h30 + 8'd52);
            end
            8'h2B: begin
                e.cls    = CLS_DATA;
                e.sextet = 6'd62;
            end
            8'h2F: begin
                e.cls    = CLS_DATA;
                e.sextet = 6'd63;
            end
            8'h3D, 8'h0A, 8'h0D: begin
                e.cls = CLS_SKIP;
            end
            default: begin
                e.cls = CLS_BAD;
            end
        endcase
        return e;
    endfunction

endpackage

/* rtl/base64_stream_decoder.sv */
// Flow: a character transferred into the queue is popped by the back part, which
// writes its result into the output register unless the output stalls.
// Throughput: one character per cycle unless the output stalls, set by the classify
// and the accumulate step in the back part; a two-entry queue decouples the sides.
// Reset: synchronous, active low; clears the queue, the accumulator, the pending
// bit count, the sticky error and the output valid flag.
// ----------------------------------------------------------------------------
// base64_stream_decoder: streaming base64 decoder, standard alphabet
// Front classifies each character, a short queue buffers it, and the back part
// accumulates sextets and delivers one result per completed byte or end of text.
// ----------------------------------------------------------------------------
module base64_stream_decoder (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // Character channel
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_text_char,
    input  logic       i_last_char,
    // Result channel
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_out_byte,
    output logic       o_byte_valid,
    output logic       o_end_of_text,
    output logic       o_failed
);

    // Front to queue
    logic                w_push;
    b64d_pkg::t_entry    w_push_entry;
    // Queue to back
    logic                w_pop;
    b64d_pkg::t_entry    w_head;
    b64d_pkg::t_q_status w_q_status;

    // Classify the character and push it; stall only while the queue is full
    b64d_front u_front (
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_text_char  (i_text_char),
        .i_last_char  (i_last_char),
        .i_q_status   (w_q_status),
        .o_push       (w_push),
        .o_push_entry (w_push_entry)
    );

    // Hold classified characters so either side may stall on its own
    b64d_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (w_push),
        .i_push_entry (w_push_entry),
        .i_pop        (w_pop),
        .o_head       (w_head),
        .o_status     (w_q_status)
    );

    // Accumulate, cut bytes, raise the end result and drive the output register.
    // Skip characters give no result unless they end the text; the back part advances
    // while the output register is empty or its transfer ends in the same cycle.
    b64d_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_head        (w_head),
        .i_q_status    (w_q_status),
        .o_pop         (w_pop),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_out_byte    (o_out_byte),
        .o_byte_valid  (o_byte_valid),
        .o_end_of_text (o_end_of_text),
        .o_failed      (o_failed)
    );

endmodule

/* rtl/b64d_front.sv */
// ----------------------------------------------------------------------------
// b64d_front: input side of the base64 stream decoder
// Accepts characters, classifies them and pushes them into the queue.
// ----------------------------------------------------------------------------
module b64d_front (
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [7:0]          i_text_char,
    input  logic                i_last_char,
    input  b64d_pkg::t_q_status i_q_status,
    output logic                o_push,
    output b64d_pkg::t_entry    o_push_entry
);

    // Stall only on a full queue
    assign o_stall      = i_q_status.full;
    assign o_push       = i_valid & ~i_q_status.full;
    assign o_push_entry = b64d_pkg::classify(i_text_char, i_last_char);

endmodule

/* rtl/b64d_queue.sv */
// ----------------------------------------------------------------------------
// b64d_queue: short queue between front and back
// Two-entry FIFO of classified characters.
// ----------------------------------------------------------------------------
module b64d_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  b64d_pkg::t_entry    i_push_entry,
    input  logic                i_pop,
    output b64d_pkg::t_entry    o_head,
    output b64d_pkg::t_q_status o_status
);

    b64d_pkg::t_entry                   r_mem [b64d_pkg::QueueDepth];
    logic [b64d_pkg::QueuePtrW-1:0]     r_wr_ptr;
    logic [b64d_pkg::QueuePtrW-1:0]     r_rd_ptr;
    logic [b64d_pkg::QueueCntW-1:0]     r_count;
    logic [b64d_pkg::QueueCntW-1:0]     n_count;
    logic                               w_push;
    logic                               w_pop;

    assign o_status.empty = (r_count == '0);
    assign o_status.full  = (r_count == b64d_pkg::QueueCntW'(b64d_pkg::QueueDepth));
    assign w_push         = i_push & ~o_status.full;
    assign w_pop          = i_pop & ~o_status.empty;
    assign o_head         = r_mem[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (w_push & ~w_pop) begin
            n_count = r_count + 1'b1;
        end else if (w_pop & ~w_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_push_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= n_count;
        end
    end

endmodule

/* rtl/b64d_back.sv */
// ----------------------------------------------------------------------------
// b64d_back: execution side of the base64 stream decoder
// Accumulates sextets, cuts bytes, tracks errors and holds the output register.
// ----------------------------------------------------------------------------
module b64d_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  b64d_pkg::t_entry    i_head,
    input  b64d_pkg::t_q_status i_q_status,
    output logic                o_pop,
    output logic                o_valid,
    input  logic                i_stall,
    output logic [7:0]          o_out_byte,
    output logic                o_byte_valid,
    output logic                o_end_of_text,
    output logic                o_failed
);

    logic [11:0] r_acc;
    logic [11:0] n_acc;
    logic [2:0]  r_pend;
    logic [2:0]  n_pend;
    logic        r_err;
    logic        n_err;
    logic        r_out_valid;
    logic [7:0]  r_out_byte;
    logic        r_byte_valid;
    logic        r_end;
    logic        r_failed;
    logic [7:0]  w_byte;
    logic        w_bvalid;
    logic        w_emit;
    logic        w_out_free;

    // Take the head whenever the output register is free or draining
    assign w_out_free = ~r_out_valid | ~i_stall;
    assign o_pop      = ~i_q_status.empty & w_out_free;

    always_comb begin
        n_acc    = r_acc;
        n_pend   = r_pend;
        n_err    = r_err;
        w_byte   = 8'd0;
        w_bvalid = 1'b0;
        case (i_head.cls)
            b64d_pkg::CLS_BAD: begin
                n_err = 1'b1;
            end
            b64d_pkg::CLS_DATA: begin
                if (!r_err) begin
                    n_acc = {r_acc[5:0], i_head.sextet};
                    case (r_pend)
                        3'd2: begin
                            w_byte   = n_acc[7:0];
                            w_bvalid = 1'b1;
                            n_pend   = 3'd0;
                        end
                        3'd4: begin
                            w_byte   = n_acc[9:2];
                            w_bvalid = 1'b1;
                            n_pend   = 3'd2;
                        end
                        3'd6: begin
                            w_byte   = n_acc[11:4];
                            w_bvalid = 1'b1;
                            n_pend   = 3'd4;
                        end
                        default: begin
                            n_pend = 3'd6;
                        end
                    endcase
                end
            end
            default: begin
            end
        endcase
    end

    assign w_emit = w_bvalid | i_head.last;

    // Payload of the output register
    always_ff @(posedge i_clk) begin
        if (o_pop && w_emit) begin
            r_out_byte   <= w_byte;
            r_byte_valid <= w_bvalid;
            r_end        <= i_head.last;
            r_failed     <= i_head.last & n_err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc       <= '0;
            r_pend      <= '0;
            r_err       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                if (i_head.last) begin
                    r_acc  <= '0;
                    r_pend <= '0;
                    r_err  <= 1'b0;
                end else begin
                    r_acc  <= n_acc;
                    r_pend <= n_pend;
                    r_err  <= n_err;
                end
            end
            if (w_out_free) begin
                r_out_valid <= o_pop & w_emit;
            end
        end
    end

    assign o_valid       = r_out_valid;
    assign o_out_byte    = r_out_byte;
    assign o_byte_valid  = r_byte_valid;
    assign o_end_of_text = r_end;
    assign o_failed      = r_failed;

endmodule
